>>> design/rtd_pkg.sv
package rtd_pkg;

	// fixed field widths
	localparam int SAMPLE_FIELD_W = 16;
	localparam int OHMS_W         = 16;
	localparam int TEMP_W         = 17;

	// defaults handed to the top level
	localparam int SAMPLE_BITS_DEF = 16;
	localparam logic [OHMS_W-1:0] PULLDOWN_RESET = 16'd1000;

	// table geometry and fixed point
	localparam int FRAC_BITS     = 8;
	localparam int TABLE_DEPTH   = 256;
	localparam int TABLE_ENTRIES = 251;
	localparam int ROM_W         = 20;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int SRCH_BITS     = $clog2(TABLE_ENTRIES - 1);
	localparam int SBIT_W        = $clog2(SRCH_BITS);

	localparam logic signed [TEMP_W-1:0] T_LOW_CODE  = TEMP_W'(-50 * (2 ** FRAC_BITS));
	localparam logic signed [TEMP_W-1:0] T_HIGH_CODE = TEMP_W'(200 * (2 ** FRAC_BITS));

	typedef enum logic [1:0] {
		RS_IN    = 2'd0,
		RS_BELOW = 2'd1,
		RS_ABOVE = 2'd2
	} range_status_t;

	typedef struct packed {
		logic [SAMPLE_FIELD_W-1:0] supply_sample;
		logic [SAMPLE_FIELD_W-1:0] pulldown_sample;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		range_status_t            range_status;
	} result_t;

	typedef enum logic [1:0] {
		SEL_LOW,
		SEL_HIGH,
		SEL_INTERP,
		SEL_TOP
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_DIV1,
		S_TAKE,
		S_RANGE,
		S_SEARCH,
		S_DIV2_LD,
		S_DIV2,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic             capture;
		logic             mul;
		logic             div1_load;
		logic             div_step;
		logic             res_take;
		logic             search_init;
		logic             search_step;
		logic             div2_load;
		logic             emit;
		res_sel_t         sel;
		logic [SBIT_W-1:0] sbit;
	} dp_cmd_t;

	typedef struct packed {
		logic pd_zero;
		logic sup_lt_pd;
		logic below;
		logic above;
		logic at_top;
	} dp_stat_t;

	typedef logic [TABLE_DEPTH-1:0][ROM_W-1:0] rom_array_t;

	// Callendar-Van Dusen resistances, -50..200 C, 1/2^FRAC_BITS ohm, rounded half up
	function automatic rom_array_t build_rom();
		rom_array_t        r;
		longint            t;
		longint            s;
		longint unsigned   u;
		r = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			t = longint'(i) - 64'sd50;
			s = 64'sd1000000000000000 + 64'sd3908300000000 * t - 64'sd577500000 * t * t;
			if (t < 0) begin
				s = s - 64'sd4183 * t * t * t * (t - 64'sd100);
			end
			u = longint'(s);
			r[i] = ROM_W'(((u << FRAC_BITS) + 64'd500000000000) / 64'd1000000000000);
		end
		return r;
	endfunction

endpackage

>>> design/rtd_ctrl.sv
module rtd_ctrl #(
	parameter int SAMPLE_BITS = rtd_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  rtd_pkg::dp_stat_t stat,
	output rtd_pkg::dp_cmd_t  cmd
);
	import rtd_pkg::*;

	localparam int NUM_W = OHMS_W + SAMPLE_BITS + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	ctrl_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		cmd     = '0;
		cmd.sel = SEL_LOW;
		cmd.sbit = cnt_q[SBIT_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.pd_zero) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_HIGH;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else if (stat.sup_lt_pd) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_LOW;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.div1_load = 1'b1;
					cnt_d   = CNT_W'(NUM_W - 1);
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_TAKE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_TAKE: begin
				cmd.res_take = 1'b1;
				state_d = S_RANGE;
			end
			S_RANGE: begin
				if (stat.below) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_LOW;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else if (stat.above) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_HIGH;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.search_init = 1'b1;
					cnt_d   = CNT_W'(SRCH_BITS - 1);
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_DIV2_LD;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_DIV2_LD: begin
				if (stat.at_top) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_TOP;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.div2_load = 1'b1;
					cnt_d   = CNT_W'(FRAC_BITS - 1);
					state_d = S_DIV2;
				end
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_FIN: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_INTERP;
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> design/rtd_dpath.sv
module rtd_dpath #(
	parameter int SAMPLE_BITS = rtd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  rtd_pkg::dp_cmd_t            cmd,
	output rtd_pkg::dp_stat_t           stat,
	input  rtd_pkg::sample_t            sample,
	input  logic [rtd_pkg::OHMS_W-1:0]  pulldown_ohms,
	output rtd_pkg::result_t            result
);
	import rtd_pkg::*;

	localparam int PROD_W = OHMS_W + SAMPLE_BITS;
	localparam int NUM_W  = PROD_W + FRAC_BITS;
	localparam int DIV_W  = (SAMPLE_BITS > ROM_W) ? SAMPLE_BITS : ROM_W;
	localparam rom_array_t ROM = build_rom();

	logic [SAMPLE_BITS-1:0] sup_q, pd_q;
	logic [PROD_W-1:0]      prod_q;
	logic [DIV_W-1:0]       den_q, rem_q;
	logic [NUM_W-1:0]       sh_q, r_q;
	logic [IDX_W-1:0]       lo_q;
	result_t                result_q;

	logic [IDX_W-1:0]       lo_nx, cand;
	logic [ROM_W-1:0]       r0, r1, rom_cand;
	logic                   cand_ok;
	logic [DIV_W:0]         din, diff;
	logic                   geq;
	logic [FRAC_BITS:0]     frac;
	logic signed [TEMP_W-1:0] interp;

	assign lo_nx    = lo_q + IDX_W'(1);
	assign cand     = lo_q | (IDX_W'(1) << cmd.sbit);
	assign r0       = ROM[lo_q];
	assign r1       = ROM[lo_nx];
	assign rom_cand = ROM[cand];
	assign cand_ok  = (cand <= IDX_W'(TABLE_ENTRIES - 2)) && (NUM_W'(rom_cand) <= r_q);

	// restoring divider step
	assign din  = {rem_q, sh_q[NUM_W-1]};
	assign geq  = (din >= {1'b0, den_q});
	assign diff = din - {1'b0, den_q};

	always_comb begin
		if (cmd.sel == SEL_TOP) begin
			frac = (FRAC_BITS + 1)'(1) << FRAC_BITS;
		end else begin
			frac = {1'b0, sh_q[FRAC_BITS-1:0]};
		end
		interp = TEMP_W'({lo_q, FRAC_BITS'(0)}) + TEMP_W'(frac) + T_LOW_CODE;
	end

	assign stat.pd_zero   = (pd_q == '0);
	assign stat.sup_lt_pd = (sup_q < pd_q);
	assign stat.below     = (r_q < NUM_W'(ROM[0]));
	assign stat.above     = (r_q > NUM_W'(ROM[TABLE_ENTRIES-1]));
	assign stat.at_top    = (r_q == NUM_W'(r1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sup_q <= SAMPLE_BITS'(sample.supply_sample);
			pd_q  <= SAMPLE_BITS'(sample.pulldown_sample);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(pulldown_ohms) * PROD_W'(sup_q - pd_q);
		end
		if (cmd.div1_load) begin
			rem_q <= '0;
			sh_q  <= {prod_q, FRAC_BITS'(0)};
			den_q <= DIV_W'(pd_q);
		end else if (cmd.div2_load) begin
			rem_q <= DIV_W'(r_q - NUM_W'(r0));
			sh_q  <= '0;
			den_q <= DIV_W'(r1 - r0);
		end else if (cmd.div_step) begin
			rem_q <= geq ? diff[DIV_W-1:0] : din[DIV_W-1:0];
			sh_q  <= {sh_q[NUM_W-2:0], geq};
		end
		if (cmd.res_take) begin
			r_q <= sh_q;
		end
		if (cmd.search_init) begin
			lo_q <= '0;
		end else if (cmd.search_step && cand_ok) begin
			lo_q <= cand;
		end
		if (cmd.emit) begin
			case (cmd.sel)
				SEL_HIGH: begin
					result_q.temperature  <= T_HIGH_CODE;
					result_q.range_status <= RS_ABOVE;
				end
				SEL_INTERP, SEL_TOP: begin
					result_q.temperature  <= interp;
					result_q.range_status <= RS_IN;
				end
				default: begin
					result_q.temperature  <= T_LOW_CODE;
					result_q.range_status <= RS_BELOW;
				end
			endcase
		end
	end

	assign result = result_q;

endmodule

>>> design/rtd_divider_to_temperature_top.sv
// Channel    | Ports                         | Transaction
// -----------+-------------------------------+-------------------------------------------
// sample in  | start, busy, sample           | taken at an edge with start high, busy low
// result out | done, result                  | one-cycle strobe on done, cannot be held off
// config     | cfg_wr_en, cfg_wr_data        | pulldown_ohms written at an edge with cfg_wr_en
//
// One transaction at a time. The bit-serial restoring divider (one quotient bit a cycle, used
// twice) and the 8-step binary table search run when the reading lands inside the table.
// Zero pulldown or supply below pulldown finish straight after the multiply, below or above
// the table after the first division, a reading exactly on the top entry after the search.
// Reset clears the controller and loads pulldown_ohms with 1000; the table is constant.
// busy falls in the cycle done is high, so the next start may be taken straight away.
module rtd_divider_to_temperature_top #(
	parameter int SAMPLE_BITS = rtd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rtd_pkg::sample_t            sample,
	output logic                        done,
	output rtd_pkg::result_t            result,
	input  logic                        cfg_wr_en,
	input  logic [rtd_pkg::OHMS_W-1:0]  cfg_wr_data
);
	import rtd_pkg::*;

	logic [OHMS_W-1:0] pulldown_ohms_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	// pulldown resistor value, whole ohms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulldown_ohms_q <= PULLDOWN_RESET;
		end else if (cfg_wr_en) begin
			pulldown_ohms_q <= cfg_wr_data;
		end
	end

	// sequencer: multiply, divide, range check, search, interpolate
	rtd_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.cmd   (cmd)
	);

	// arithmetic, table and result register
	rtd_dpath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.pulldown_ohms(pulldown_ohms_q),
		.result       (result)
	);

	// a result strobe leaves the block free for the next transaction
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transaction makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("start not taken");

	// in-range temperatures stay within the table span
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.range_status == RS_IN) |->
		(result.temperature >= T_LOW_CODE && result.temperature <= T_HIGH_CODE))
		else $error("interpolated temperature out of span");

	// out-of-range results saturate to the matching end of the table; only the above-range end is checked here
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.range_status == RS_ABOVE) |-> (result.temperature == T_HIGH_CODE))
		else $error("above-range result not saturated");

endmodule

>>> sim/rtd_divider_to_temperature_top_tb.sv
module rtd_divider_to_temperature_top_tb;
	import rtd_pkg::*;

	// Resistance table, -50..200 C, 1/256 ohm, rounded half up. Built independently of the package.
	class temp_scoreboard;
		bit [19:0]          res_table[TABLE_ENTRIES];
		bit [15:0]          ohms;
		result_t            pending[$];
		int                 mismatches;

		function new();
			longint            t;
			longint            s;
			longint unsigned   u;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				t = longint'(i) - 64'sd50;
				s = 64'sd1000000000000000 + 64'sd3908300000000 * t - 64'sd577500000 * t * t;
				if (t < 0) begin
					s = s - 64'sd4183 * t * t * t * (t - 64'sd100);
				end
				u = s;
				res_table[i] = 20'(((u << 8) + 64'd500000000000) / 64'd1000000000000);
			end
			ohms = 16'd1000;
			mismatches = 0;
		endfunction

		function void note_sample(sample_t smp);
			result_t          exp_res;
			longint unsigned  r;
			longint unsigned  frac;
			int               idx;
			exp_res.range_status = RS_IN;
			if (smp.pulldown_sample == 0) begin
				exp_res.temperature = T_HIGH_CODE;
				exp_res.range_status = RS_ABOVE;
			end else if (smp.supply_sample < smp.pulldown_sample) begin
				exp_res.temperature = T_LOW_CODE;
				exp_res.range_status = RS_BELOW;
			end else begin
				r = ((64'(ohms) * (smp.supply_sample - smp.pulldown_sample)) << 8)
					/ smp.pulldown_sample;
				if (r < res_table[0]) begin
					exp_res.temperature = T_LOW_CODE;
					exp_res.range_status = RS_BELOW;
				end else if (r > res_table[TABLE_ENTRIES-1]) begin
					exp_res.temperature = T_HIGH_CODE;
					exp_res.range_status = RS_ABOVE;
				end else begin
					idx = 0;
					while (idx < TABLE_ENTRIES - 2 && res_table[idx+1] <= r) idx++;
					frac = ((r - res_table[idx]) << 8) / (res_table[idx+1] - res_table[idx]);
					exp_res.temperature = 17'((idx - 50) * 256 + frac);
				end
			end
			pending.push_back(exp_res);
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_res = pending.pop_front();
			if (got.temperature !== exp_res.temperature ||
				got.range_status !== exp_res.range_status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp temp %0d st %0d, got temp %0d st %0d",
						exp_res.temperature, exp_res.range_status,
						got.temperature, got.range_status);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	sample_t         sample;
	logic            done;
	result_t         result;
	logic            cfg_wr_en;
	logic [15:0]     cfg_wr_data;
	temp_scoreboard  sb;

	rtd_divider_to_temperature_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// results cannot be held off: every done strobe is one transaction
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// short gaps mostly, an occasional long one, plenty of back-to-back
	function automatic int idle_len();
		int n;
		n = ($urandom_range(0, 9) < 5) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 120);
		return n;
	endfunction

	// holds start until the block takes the transaction; start stays high on a zero gap
	task automatic send_sample(input logic [15:0] sup, input logic [15:0] pd);
		sample_t smp;
		int      n;
		smp.supply_sample = sup;
		smp.pulldown_sample = pd;
		start <= 1'b1;
		sample <= smp;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_sample(smp);
		n = idle_len();
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait for the queue to drain plus the slowest no-result tail before any write
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_ohms(input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.ohms = val;
	endtask

	// resistance R (whole ohms) turned into a realistic divider reading
	task automatic send_ohms_reading(input int r_ohm);
		int pd;
		longint sup;
		pd = $urandom_range(2000, 30000);
		if (sb.ohms == 0)
			sup = pd;
		else
			sup = pd + (longint'(pd) * r_ohm + sb.ohms / 2) / sb.ohms;
		if (sup > 65535) sup = 65535;
		send_sample(16'(sup), 16'(pd));
	endtask

	initial begin
		logic [15:0] ohms_set[5];
		ohms_set = '{16'd1, 16'd65535, 16'd0, 16'd2200, 16'd1000};
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero pulldown, supply below pulldown, table ends, extremes
		send_sample(16'd0, 16'd0);
		send_sample(16'hFFFF, 16'd0);
		send_sample(16'd100, 16'd200);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'hFFFF, 16'd1);
		send_sample(16'd0, 16'hFFFF);
		send_sample(16'd2000, 16'd1000);
		send_sample(16'd20000, 16'd10000);
		send_sample(16'd1803, 16'd1000);
		send_sample(16'd1804, 16'd1000);
		send_sample(16'd1802, 16'd1000);
		send_sample(16'd1000, 16'd1000);
		send_sample(16'hAAAA, 16'h5555);
		send_sample(16'h5555, 16'h2AAA);
		send_sample(16'd50000, 16'd27000);
		// pause until every expected result is back
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			write_ohms(ohms_set[phase]);
			for (int k = 0; k < 110; k++) begin
				if ($urandom_range(0, 9) < 7)
					send_ohms_reading($urandom_range(780, 1800));
				else
					send_sample(16'($urandom), 16'($urandom));
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("rtd_divider_to_temperature_top_tb: done, clean");
		else
			$display("rtd_divider_to_temperature_top_tb: done, errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("rtd_divider_to_temperature_top_tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
design/rtd_pkg.sv
design/rtd_ctrl.sv
design/rtd_dpath.sv
design/rtd_divider_to_temperature_top.sv
sim/rtd_divider_to_temperature_top_tb.sv
